FILE: design/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants and types for the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int SCREEN_W  = 800;
  localparam int SCREEN_H  = 480;
  localparam int MAX_SRC_W = 1024;
  localparam int MAX_SRC_H = 512;

  localparam int STORE_AW = 19;   // log2(MAX_SRC_W * MAX_SRC_H)
  localparam int DIV_NW   = 36;   // dividend / quotient width
  localparam int DIV_DW   = 11;   // divisor width
  localparam int DIV_CW   = 6;    // iteration counter width

  typedef enum logic [1:0] {
    CFG_SRC_W   = 2'd0,
    CFG_SRC_H   = 2'd1,
    CFG_PLACE_X = 2'd2,
    CFG_PLACE_Y = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIM_START,
    ST_DIM_WAIT,
    ST_POS,
    ST_X_START,
    ST_X_WAIT,
    ST_Y_START,
    ST_Y_WAIT,
    ST_BASE,
    ST_READ,
    ST_MAC,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROD,
    OP_DIM_START,
    OP_DIM_CAPT,
    OP_POS,
    OP_X_START,
    OP_X_CAPT,
    OP_Y_START,
    OP_Y_CAPT,
    OP_BASE,
    OP_READ,
    OP_MAC,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] tap;   // bit0: right neighbor, bit1: lower neighbor
  } cmd_t;

  typedef struct packed {
    logic offscreen;
    logic dims_empty;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

FILE: design/bis_div.sv
// ----------------------------------------------------------------------------
// bis_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bis_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bis_pkg::DIV_NW-1:0] dividend,
  input  logic [bis_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [bis_pkg::DIV_NW-1:0] quotient
);

  logic                       busy;
  logic [bis_pkg::DIV_CW-1:0] cnt;
  logic [bis_pkg::DIV_DW-1:0] rem;
  logic [bis_pkg::DIV_DW-1:0] dvs;
  logic [bis_pkg::DIV_NW-1:0] q;
  logic [bis_pkg::DIV_DW:0]   trial;
  logic                       ge;

  assign trial    = {rem, q[bis_pkg::DIV_NW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bis_pkg::DIV_CW'(bis_pkg::DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == bis_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (ge) begin
        rem <= bis_pkg::DIV_DW'(trial - {1'b0, dvs});
        q   <= {q[bis_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem <= trial[bis_pkg::DIV_DW-1:0];
        q   <= {q[bis_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/bis_datapath.sv
// ----------------------------------------------------------------------------
// bis_datapath
// Config registers, frame store, size/coordinate math and blend accumulators.
// ----------------------------------------------------------------------------
module bis_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [10:0]         cfg_data,
  input  logic [23:0]         s_tdata,
  input  bis_pkg::cmd_t       cmd,
  output bis_pkg::stat_t      stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,
  output logic                m_tlast
);

  logic [10:0] src_w;
  logic [9:0]  src_h;
  logic [9:0]  place_x;
  logic [8:0]  place_y;

  logic [23:0] store [(1 << bis_pkg::STORE_AW)];
  logic [bis_pkg::STORE_AW-1:0] load_index;
  logic [bis_pkg::STORE_AW:0]   load_next;
  logic [bis_pkg::STORE_AW:0]   src_size;

  logic [10:0] sw;
  logic [9:0]  sh;
  logic [9:0]  sw_m1;
  logic [8:0]  sh_m1;
  logic [10:0] aw_full;
  logic [9:0]  ah_full;
  logic [9:0]  aw;
  logic [8:0]  ah;

  logic [19:0] prod_w;
  logic [19:0] prod_h;
  logic        fit_now;
  logic        fit_w;
  logic [9:0]  aw_r;
  logic [8:0]  ah_r;
  logic [9:0]  dw;
  logic [8:0]  dh;
  logic [9:0]  col;
  logic [8:0]  row;

  logic        div_start;
  logic [bis_pkg::DIV_NW-1:0] div_num;
  logic [bis_pkg::DIV_DW-1:0] div_den;
  logic        div_done;
  logic [bis_pkg::DIV_NW-1:0] div_quot;

  logic [19:0] col_prod;
  logic [17:0] row_prod;
  logic [9:0]  x0_raw;
  logic [9:0]  y0_raw;
  logic [9:0]  x0, x1;
  logic [8:0]  y0;
  logic [15:0] fx, fy;
  logic [10:0] x1_sum;
  logic [9:0]  y1_sum;
  logic [bis_pkg::STORE_AW-1:0] base0, base1;

  logic [bis_pkg::STORE_AW-1:0] rd_addr;
  logic [23:0] rdata;
  logic [16:0] wx, wy;
  logic [33:0] wgt;
  logic [43:0] acc_r, acc_g, acc_b;
  logic [7:0]  res_r, res_g, res_b;
  logic        last;

  // Effective sizes clamped to 1..max
  always_comb begin
    if (src_w == '0) sw = 11'd1;
    else if (src_w > 11'(bis_pkg::MAX_SRC_W)) sw = 11'(bis_pkg::MAX_SRC_W);
    else sw = src_w;
    if (src_h == '0) sh = 10'd1;
    else if (src_h > 10'(bis_pkg::MAX_SRC_H)) sh = 10'(bis_pkg::MAX_SRC_H);
    else sh = src_h;
  end

  assign sw_m1    = 10'(sw - 11'd1);
  assign sh_m1    = 9'(sh - 10'd1);
  assign aw_full  = 11'(bis_pkg::SCREEN_W) - {1'b0, place_x};
  assign ah_full  = 10'(bis_pkg::SCREEN_H) - {1'b0, place_y};
  assign aw       = aw_full[9:0];
  assign ah       = ah_full[8:0];
  assign src_size = (bis_pkg::STORE_AW+1)'(sw * sh);
  assign load_next = {1'b0, load_index} + 1'b1;
  assign fit_now  = prod_w <= prod_h;

  assign stat.offscreen  = (place_x >= 10'(bis_pkg::SCREEN_W)) ||
                           (place_y >= 9'(bis_pkg::SCREEN_H));
  assign stat.dims_empty = (dw == '0) || (dh == '0);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !m_tvalid || m_tready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w   <= 11'd1;
      src_h   <= 10'd1;
      place_x <= '0;
      place_y <= '0;
    end else if (cfg_we) begin
      case (bis_pkg::cfg_idx_t'(cfg_addr))
        bis_pkg::CFG_SRC_W:   src_w   <= cfg_data;
        bis_pkg::CFG_SRC_H:   src_h   <= cfg_data[9:0];
        bis_pkg::CFG_PLACE_X: place_x <= cfg_data[9:0];
        bis_pkg::CFG_PLACE_Y: place_y <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Divider operand select
  assign col_prod = col * sw_m1;
  assign row_prod = row * sh_m1;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      bis_pkg::OP_DIM_START: begin
        div_start = 1'b1;
        div_num   = bis_pkg::DIV_NW'(fit_now ? prod_w : prod_h);
        div_den   = fit_now ? sw : {1'b0, sh};
      end
      bis_pkg::OP_X_START: begin
        div_start = 1'b1;
        div_num   = {col_prod, 16'h0000};
        div_den   = {1'b0, dw - 10'd1};
      end
      bis_pkg::OP_Y_START: begin
        div_start = 1'b1;
        div_num   = bis_pkg::DIV_NW'({row_prod, 16'h0000});
        div_den   = {2'b00, dh - 9'd1};
      end
      default: ;
    endcase
  end

  bis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign x0_raw = div_quot[25:16];
  assign y0_raw = div_quot[25:16];
  assign x1_sum = {1'b0, x0} + 11'd1;
  assign y1_sum = {1'b0, y0} + 10'd1;
  assign last   = (col + 10'd1 == dw) && (row + 9'd1 == dh);

  assign rd_addr = (cmd.tap[1] ? base1 : base0) +
                   bis_pkg::STORE_AW'(cmd.tap[0] ? x1 : x0);
  assign wx      = cmd.tap[0] ? {1'b0, fx} : 17'h10000 - {1'b0, fx};
  assign wy      = cmd.tap[1] ? {1'b0, fy} : 17'h10000 - {1'b0, fy};

  assign res_r = (acc_r[43:32] > 12'd255) ? 8'hFF : acc_r[39:32];
  assign res_g = (acc_g[43:32] > 12'd255) ? 8'hFF : acc_g[39:32];
  assign res_b = (acc_b[43:32] > 12'd255) ? 8'hFF : acc_b[39:32];

  // Frame store
  always_ff @(posedge clk) begin
    if (cmd.op == bis_pkg::OP_LOAD) begin
      store[load_index] <= s_tdata;
    end
    if (cmd.op == bis_pkg::OP_READ) begin
      rdata <= store[rd_addr];
    end
  end

  // Control-side position state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      col        <= '0;
      row        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.op == bis_pkg::OP_LOAD) begin
        load_index <= (load_next >= src_size) ? '0 : load_next[bis_pkg::STORE_AW-1:0];
      end
      if (cmd.op == bis_pkg::OP_POS) begin
        if (col >= dw || row >= dh) begin
          col <= '0;
          row <= '0;
        end
      end
      if (cmd.op == bis_pkg::OP_EMIT) begin
        m_tvalid <= 1'b1;
        if (col + 10'd1 >= dw) begin
          col <= '0;
          row <= (row + 9'd1 >= dh) ? '0 : row + 9'd1;
        end else begin
          col <= col + 10'd1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Arithmetic payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      bis_pkg::OP_PROD: begin
        prod_w <= aw * sh;
        prod_h <= ah * sw;
        aw_r   <= aw;
        ah_r   <= ah;
      end
      bis_pkg::OP_DIM_START: fit_w <= fit_now;
      bis_pkg::OP_DIM_CAPT: begin
        if (fit_w) begin
          dw <= aw_r;
          dh <= div_quot[8:0];
        end else begin
          dw <= div_quot[9:0];
          dh <= ah_r;
        end
      end
      bis_pkg::OP_X_CAPT: begin
        if (dw <= 10'd1) begin
          x0 <= '0;
          fx <= '0;
        end else begin
          x0 <= ({1'b0, x0_raw} >= sw) ? 10'(sw - 11'd1) : x0_raw;
          fx <= div_quot[15:0];
        end
      end
      bis_pkg::OP_Y_CAPT: begin
        if (dh <= 9'd1) begin
          y0 <= '0;
          fy <= '0;
        end else begin
          y0 <= (y0_raw >= sh) ? 9'(sh - 10'd1) : y0_raw[8:0];
          fy <= div_quot[15:0];
        end
      end
      bis_pkg::OP_BASE: begin
        x1    <= (x1_sum < sw) ? x1_sum[9:0] : x0;
        base0 <= bis_pkg::STORE_AW'(y0 * sw);
        base1 <= bis_pkg::STORE_AW'(((y1_sum < sh) ? y1_sum[8:0] : y0) * sw);
        acc_r <= '0;
        acc_g <= '0;
        acc_b <= '0;
      end
      bis_pkg::OP_READ: wgt <= wx * wy;
      bis_pkg::OP_MAC: begin
        acc_r <= acc_r + 44'(rdata[23:16] * wgt);
        acc_g <= acc_g + 44'(rdata[15:8] * wgt);
        acc_b <= acc_b + 44'(rdata[7:0] * wgt);
      end
      bis_pkg::OP_EMIT: begin
        m_tdata <= {5'b0, res_r, res_g, res_b, 9'(row + place_y), 10'(col + place_x)};
        m_tlast <= last;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/bis_ctrl.sv
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer: accepts items and steps the datapath through one emit.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tuser,
  output logic           s_tready,
  input  bis_pkg::stat_t stat,
  output bis_pkg::cmd_t  cmd
);

  bis_pkg::state_t state, state_next;
  logic [1:0] tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      if (state == bis_pkg::ST_BASE) tap <= '0;
      else if (state == bis_pkg::ST_MAC) tap <= tap + 2'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bis_pkg::ST_IDLE:
        if (s_tvalid && s_tuser) state_next = bis_pkg::ST_DIM_START;
      bis_pkg::ST_DIM_START:
        state_next = stat.offscreen ? bis_pkg::ST_IDLE : bis_pkg::ST_DIM_WAIT;
      bis_pkg::ST_DIM_WAIT:
        if (stat.div_done) state_next = bis_pkg::ST_POS;
      bis_pkg::ST_POS:
        state_next = stat.dims_empty ? bis_pkg::ST_IDLE : bis_pkg::ST_X_START;
      bis_pkg::ST_X_START: state_next = bis_pkg::ST_X_WAIT;
      bis_pkg::ST_X_WAIT:
        if (stat.div_done) state_next = bis_pkg::ST_Y_START;
      bis_pkg::ST_Y_START: state_next = bis_pkg::ST_Y_WAIT;
      bis_pkg::ST_Y_WAIT:
        if (stat.div_done) state_next = bis_pkg::ST_BASE;
      bis_pkg::ST_BASE:    state_next = bis_pkg::ST_READ;
      bis_pkg::ST_READ:    state_next = bis_pkg::ST_MAC;
      bis_pkg::ST_MAC:
        state_next = (tap == 2'd3) ? bis_pkg::ST_EMIT : bis_pkg::ST_READ;
      bis_pkg::ST_EMIT:
        if (stat.out_free) state_next = bis_pkg::ST_IDLE;
      default: state_next = bis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd.op   = bis_pkg::OP_NONE;
    cmd.tap  = tap;
    case (state)
      bis_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) cmd.op = s_tuser ? bis_pkg::OP_PROD : bis_pkg::OP_LOAD;
      end
      bis_pkg::ST_DIM_START:
        if (!stat.offscreen) cmd.op = bis_pkg::OP_DIM_START;
      bis_pkg::ST_DIM_WAIT:
        if (stat.div_done) cmd.op = bis_pkg::OP_DIM_CAPT;
      bis_pkg::ST_POS:
        if (!stat.dims_empty) cmd.op = bis_pkg::OP_POS;
      bis_pkg::ST_X_START: cmd.op = bis_pkg::OP_X_START;
      bis_pkg::ST_X_WAIT:
        if (stat.div_done) cmd.op = bis_pkg::OP_X_CAPT;
      bis_pkg::ST_Y_START: cmd.op = bis_pkg::OP_Y_START;
      bis_pkg::ST_Y_WAIT:
        if (stat.div_done) cmd.op = bis_pkg::OP_Y_CAPT;
      bis_pkg::ST_BASE: cmd.op = bis_pkg::OP_BASE;
      bis_pkg::ST_READ: cmd.op = bis_pkg::OP_READ;
      bis_pkg::ST_MAC:  cmd.op = bis_pkg::OP_MAC;
      bis_pkg::ST_EMIT:
        if (stat.out_free) cmd.op = bis_pkg::OP_EMIT;
      default: ;
    endcase
  end

endmodule

FILE: design/bilinear_image_scaler_top.sv
// Load transaction: store written at acceptance.
// Emit transaction: three passes of the one-bit-per-cycle divider (size, column, row)
// plus four serial reads of the single-port frame store; stops early if offscreen or empty.
// Results sit in an output register; the next item is taken while one waits.
// Synchronous active-high reset clears position, load index and config (sizes 1);
// frame store contents are undefined until loaded.
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top
// Frame store loader and bilinear scaler to screen placement.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // screen_col[9:0], screen_row[18:10], pixel_color[42:19]
  output logic        m_tlast    // last_pixel
);

  bis_pkg::cmd_t  cmd;
  bis_pkg::stat_t stat;

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bis_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: design/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks for the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module bis_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
    else $error("load transaction produced a result");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("emit did not occupy the block");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without an emit in progress");

endmodule

bind bilinear_image_scaler_top bis_checker u_bis_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear image scaler: loads source frames,
// requests destination pixels and compares every output transaction against
// a cycle-free model of the scaler, under random valid/ready idling.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [23:0] color;
    logic        last;
  } pixel_t;

  localparam int SETTLE = 400;        // cycles after last result before reconfig
  localparam int LIMIT  = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [10:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  bilinear_image_scaler_top dut (.*);

  always #10 clk = ~clk;

  // scaler model state
  logic [23:0] frame_mem [int];
  int unsigned load_ptr, cur_col, cur_row;
  int unsigned reg_sw, reg_sh, reg_px, reg_py;
  pixel_t      pixel_q[$];

  int  fail_cnt = 0;
  int  send_idle = 0, recv_idle = 0;
  int  item_cnt = 0;
  int  cycle_cnt = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned src_coord(longint unsigned pos, longint unsigned sl,
                                                longint unsigned dl);
    if (dl <= 1) return 0;
    return (pos * (sl - 1) * 65536) / (dl - 1);
  endfunction

  task automatic model_item(bit func, logic [23:0] pix);
    int unsigned sw, sh, x0, x1, y0, y1;
    longint unsigned aw, ah, dw, dh, sx, sy, fx, fy, w00, w01, w10, w11, acc;
    logic [23:0] p00, p01, p10, p11, color;
    pixel_t e;
    sw = clamp_dim(reg_sw, bis_pkg::MAX_SRC_W);
    sh = clamp_dim(reg_sh, bis_pkg::MAX_SRC_H);
    if (!func) begin
      frame_mem[load_ptr] = pix;
      load_ptr++;
      if (load_ptr >= sw * sh) load_ptr = 0;
      return;
    end
    if (reg_px >= bis_pkg::SCREEN_W || reg_py >= bis_pkg::SCREEN_H) return;
    aw = bis_pkg::SCREEN_W - reg_px;
    ah = bis_pkg::SCREEN_H - reg_py;
    if (aw * sh <= ah * sw) begin
      dw = aw;
      dh = (sh * aw) / sw;
    end else begin
      dh = ah;
      dw = (sw * ah) / sh;
    end
    if (dw == 0 || dh == 0) return;
    if (cur_col >= dw || cur_row >= dh) begin
      cur_col = 0;
      cur_row = 0;
    end
    sx = src_coord(cur_col, sw, dw);
    sy = src_coord(cur_row, sh, dh);
    x0 = 32'(sx >> 16);
    y0 = 32'(sy >> 16);
    fx = sx & 64'hFFFF;
    fy = sy & 64'hFFFF;
    if (x0 >= sw) x0 = sw - 1;
    if (y0 >= sh) y0 = sh - 1;
    x1 = (x0 + 1 < sw) ? x0 + 1 : x0;
    y1 = (y0 + 1 < sh) ? y0 + 1 : y0;
    p00 = frame_mem[y0 * sw + x0];
    p01 = frame_mem[y0 * sw + x1];
    p10 = frame_mem[y1 * sw + x0];
    p11 = frame_mem[y1 * sw + x1];
    w00 = (65536 - fx) * (65536 - fy);
    w01 = fx * (65536 - fy);
    w10 = (65536 - fx) * fy;
    w11 = fx * fy;
    for (int s = 0; s < 24; s += 8) begin
      acc = p00[s +: 8] * w00 + p01[s +: 8] * w01 + p10[s +: 8] * w10 + p11[s +: 8] * w11;
      acc = acc >> 32;
      if (acc > 255) acc = 255;
      color[s +: 8] = acc[7:0];
    end
    e.col   = 10'(cur_col + reg_px);
    e.row   = 9'(cur_row + reg_py);
    e.color = color;
    e.last  = (cur_col + 1 == dw) && (cur_row + 1 == dh);
    pixel_q.push_back(e);
    cur_col++;
    if (cur_col >= dw) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= dh) cur_row = 0;
    end
  endtask

  task automatic send_item(bit func, logic [23:0] pix);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {pix[7:0], pix[15:8], pix[23:16]};   // red low, blue high
    do @(posedge clk); while (!s_tready);
    model_item(func, pix);
    item_cnt++;
  endtask

  task automatic load_pixel();
    send_item(1'b0, 24'($urandom));
  endtask

  task automatic emit_pixel();
    send_item(1'b1, 24'($urandom));
  endtask

  // Drain outstanding results, then give a resultless emit time to finish.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(bis_pkg::cfg_idx_t idx, logic [10:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      bis_pkg::CFG_SRC_W:   reg_sw = 32'(val);
      bis_pkg::CFG_SRC_H:   reg_sh = 32'(val[9:0]);
      bis_pkg::CFG_PLACE_X: reg_px = 32'(val[9:0]);
      bis_pkg::CFG_PLACE_Y: reg_py = 32'(val[8:0]);
      default: ;
    endcase
  endtask

  task automatic setup(int unsigned sw, int unsigned sh, int unsigned px, int unsigned py);
    wait_quiet();
    write_reg(bis_pkg::CFG_SRC_W, 11'(sw));
    write_reg(bis_pkg::CFG_SRC_H, 11'(sh));
    write_reg(bis_pkg::CFG_PLACE_X, 11'(px));
    write_reg(bis_pkg::CFG_PLACE_Y, 11'(py));
    cfg_we <= 1'b0;
  endtask

  // size+1 loads cover every entry whatever the load pointer was
  task automatic load_frame();
    int unsigned n;
    n = clamp_dim(reg_sw, bis_pkg::MAX_SRC_W) * clamp_dim(reg_sh, bis_pkg::MAX_SRC_H) + 1;
    repeat (n) load_pixel();
  endtask

  // Fill entries 0..k-1, running the load pointer around to zero first
  task automatic load_prefix(int unsigned k);
    int unsigned size, n;
    size = clamp_dim(reg_sw, bis_pkg::MAX_SRC_W) * clamp_dim(reg_sh, bis_pkg::MAX_SRC_H);
    if (load_ptr == 0) n = k;
    else if (load_ptr >= size) n = k + 1;
    else n = size - load_ptr + k;
    repeat (n) load_pixel();
  endtask

  task automatic test_reset_size();
    load_pixel();
    repeat (3) emit_pixel();
  endtask

  task automatic test_clamped_size();
    setup(0, 0, 0, 0);
    load_frame();
    repeat (2) emit_pixel();
    setup(3, 1023, 790, 0);   // height clamps to the maximum
    load_prefix(6);           // two destination pixels read source rows 0 and 1
    repeat (2) emit_pixel();
  endtask

  task automatic test_offscreen();
    setup(2, 2, 1023, 0);
    load_frame();
    repeat (2) emit_pixel();
    setup(2, 2, 0, 511);
    repeat (2) emit_pixel();
  endtask

  task automatic test_empty_dest();
    setup(1024, 1, 0, 0);     // destination height rounds to zero
    repeat (2) emit_pixel();
  endtask

  task automatic test_frame_wrap();
    setup(2, 1, 796, 478);    // 4x2 destination, last flag then wrap
    load_frame();
    repeat (9) emit_pixel();
    setup(1, 1, 799, 479);    // single pixel destination
    load_frame();
    repeat (2) emit_pixel();
  endtask

  task automatic test_random();
    int unsigned sw, sh, px, py;
    int phase = 0;
    while (item_cnt < 750) begin
      if (item_cnt < 250) begin
        send_idle = 24; recv_idle = 63;
      end else if (item_cnt < 500) begin
        send_idle = 63; recv_idle = 24;
      end else begin
        send_idle = 0;  recv_idle = 0;
      end
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 12);
      if (phase == 0) begin sw = 2047; sh = 1; end
      else if (phase == 1) begin sw = 1; sh = 512; end
      else if ($urandom_range(9) == 0) sw = 0;
      px = $urandom_range(3) == 0 ? $urandom_range(780, 799) : $urandom_range(0, 799);
      py = $urandom_range(3) == 0 ? $urandom_range(465, 479) : $urandom_range(0, 479);
      if ($urandom_range(14) == 0) px = $urandom_range(800, 1023);
      if ($urandom_range(14) == 0) py = $urandom_range(480, 511);
      setup(sw, sh, px, py);
      // the two extreme shapes (width or height at the maximum) give an empty destination, so nothing is read
      if (phase > 1) load_frame();
      repeat ($urandom_range(5, 25)) begin
        if ($urandom_range(6) == 0) load_pixel();
        else emit_pixel();
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    pixel_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected output transaction col=%0d row=%0d", m_tdata[9:0], m_tdata[18:10]);
        fail_cnt++;
      end else begin
        e = pixel_q.pop_front();
        if (m_tdata[9:0] !== e.col) begin
          $error("screen_col expected %0d got %0d", e.col, m_tdata[9:0]); fail_cnt++;
        end
        if (m_tdata[18:10] !== e.row) begin
          $error("screen_row expected %0d got %0d", e.row, m_tdata[18:10]); fail_cnt++;
        end
        if (m_tdata[42:19] !== e.color) begin
          $error("pixel_color expected %06h got %06h", e.color, m_tdata[42:19]); fail_cnt++;
        end
        if (m_tlast !== e.last) begin
          $error("last_pixel expected %0b got %0b", e.last, m_tlast); fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    load_ptr = 0; cur_col = 0; cur_row = 0;
    reg_sw = 1; reg_sh = 1; reg_px = 0; reg_py = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 24; recv_idle = 63;
    test_reset_size();
    test_clamped_size();
    test_offscreen();
    test_empty_dest();
    test_frame_wrap();
    test_random();
    wait_quiet();
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bis_pkg.sv
design/bis_div.sv
design/bis_datapath.sv
design/bis_ctrl.sv
design/bilinear_image_scaler_top.sv
design/bis_checker.sv
tb/tb.sv
